/* hdl/plc_on_off_pulse_timer_assert.svh */
// Assertion macros for the on/off/pulse timer.
`ifndef PLC_ON_OFF_PULSE_TIMER_ASSERT_SVH
`define PLC_ON_OFF_PULSE_TIMER_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cond implies prop in the same cycle.
`define PLC_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Check that cond implies prop in the following cycle.
`define PLC_ASSERT_NXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define PLC_ASSERT_IMP(label, clk, rst, cond, prop, msg)
`define PLC_ASSERT_NXT(label, clk, rst, cond, prop, msg)

`endif

`endif

/* hdl/plc_tmr_pkg.sv */
// Constants and types shared by the on/off/pulse timer.
`timescale 1ns / 1ps

package plc_tmr_pkg;

   localparam int TIME_WIDTH        = 24;
   localparam int ELAPSED_WIDTH     = TIME_WIDTH + 1;
   localparam int OUT_ELAPSED_WIDTH = 25;
   localparam int DELAY_WIDTH       = 24;
   localparam int FRAMES_WIDTH      = 9;
   localparam int MODE_WIDTH        = 2;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH    = 24;
   localparam int CALC_WIDTH =
      ((ELAPSED_WIDTH > DELAY_WIDTH) ? ELAPSED_WIDTH : DELAY_WIDTH) + 2;

   typedef logic [MODE_WIDTH-1:0]      mode_type;
   typedef logic [CSR_INDEX_WIDTH-1:0] csr_index_type;
   typedef logic [ELAPSED_WIDTH-1:0]   elapsed_type;
   typedef logic [DELAY_WIDTH-1:0]     delay_type;
   typedef logic [FRAMES_WIDTH-1:0]    frames_type;
   typedef logic [CALC_WIDTH-1:0]      calc_type;

   localparam mode_type MODE_ON_DELAY  = 2'd0;
   localparam mode_type MODE_OFF_DELAY = 2'd1;
   localparam mode_type MODE_PULSE     = 2'd2;

   localparam csr_index_type CSR_TIMER_MODE       = 2'd0;
   localparam csr_index_type CSR_DELAY_TICKS      = 2'd1;
   localparam csr_index_type CSR_FRAMES_PER_CYCLE = 2'd2;

   localparam frames_type  FRAMES_RESET = 9'd16;
   localparam elapsed_type ELAPSED_MAX  = '1;

endpackage

/* hdl/plc_on_off_pulse_timer.sv */
// Top level of the on-delay / off-delay / pulse timer.
`timescale 1ns / 1ps
// The rsp_ word is registered and appears in the cycle after its req_ word is accepted.
// Throughput: one word per cycle while rsp_ready holds; the state update (one add/clamp on the
//   elapsed count) and the result register are both written on acceptance.
// Reset: synchronous, active high; clears the state and the result valid,
//   and sets mode on-delay, delay 0 and 16 frames per cycle.
`include "plc_on_off_pulse_timer_assert.svh"

module plc_on_off_pulse_timer
   import plc_tmr_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_s_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_q_out,
   output logic [OUT_ELAPSED_WIDTH-1:0] rsp_elapsed_ticks,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]    csr_data
);

   // configuration registers
   mode_type    timer_mode_ff;
   delay_type   delay_ticks_ff;
   frames_type  frames_ff;

   // timer state
   logic        q_level_ff, q_level_in;
   elapsed_type elapsed_ff, elapsed_in;
   logic        prev_input_ff, prev_input_in;

   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_q_ff;
   logic [OUT_ELAPSED_WIDTH-1:0] rsp_elapsed_ff;

   logic        req_take;
   logic        rise;
   elapsed_type adv_from;
   elapsed_type adv_result;

   // Accept a new word whenever the result slot is free or being drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_q_out         = rsp_q_ff;
   assign rsp_elapsed_ticks = rsp_elapsed_ff;

   // True when a count lies beyond the programmed delay.
   function automatic logic past_delay(elapsed_type e, delay_type d);
      return calc_type'(e) > calc_type'(d);
   endfunction

   // Rising edge of the input, only meaningful in pulse mode.
   assign rise = req_s_in && !prev_input_ff;

   // Pulse mode restarts the count on a rising edge before advancing.
   assign adv_from = (timer_mode_ff == MODE_PULSE && rise) ? '0 : elapsed_ff;

   // Advance unit: step towards one past the delay, then creep by one,
   // saturating at the top of the count; with zero frames the count holds.
   always_comb begin
      calc_type sum;
      calc_type lim;
      calc_type nxt;
      sum = calc_type'(adv_from) + calc_type'(frames_ff);
      lim = calc_type'(delay_ticks_ff) + calc_type'(1);
      nxt = (sum < lim) ? sum : lim;
      if (frames_ff == '0) begin
         adv_result = adv_from;
      end else if (past_delay(adv_from, delay_ticks_ff)) begin
         adv_result = (adv_from == ELAPSED_MAX) ? adv_from : adv_from + elapsed_type'(1);
      end else if (nxt > calc_type'(ELAPSED_MAX)) begin
         adv_result = ELAPSED_MAX;
      end else begin
         adv_result = nxt[ELAPSED_WIDTH-1:0];
      end
   end

   // Mode rules: next output level and count for this word.
   always_comb begin
      q_level_in    = q_level_ff;
      elapsed_in    = elapsed_ff;
      prev_input_in = prev_input_ff;
      case (timer_mode_ff)
         MODE_ON_DELAY: begin
            // Count while the input holds and the output is still off.
            elapsed_in = (req_s_in && !q_level_ff) ? adv_result : '0;
            if (past_delay(elapsed_in, delay_ticks_ff) && req_s_in) begin
               q_level_in = 1'b1;
            end else if (!req_s_in) begin
               q_level_in = 1'b0;
            end
         end
         MODE_OFF_DELAY: begin
            if (req_s_in) begin
               q_level_in = 1'b1;
               elapsed_in = '0;
            end else if (past_delay(elapsed_ff, delay_ticks_ff)) begin
               q_level_in = 1'b0;
               elapsed_in = '0;
            end else if (q_level_ff) begin
               elapsed_in = adv_result;
            end
         end
         MODE_PULSE: begin
            prev_input_in = req_s_in;
            if (past_delay(adv_from, delay_ticks_ff)) begin
               q_level_in = 1'b0;
               elapsed_in = '0;
            end else if (q_level_ff || rise) begin
               q_level_in = 1'b1;
               elapsed_in = adv_result;
            end
         end
         default: begin
            // Unused mode: hold everything and report the current state.
         end
      endcase
   end

   // Result valid: set on a new word, drop once the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Configuration writes; an unknown index is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff  <= MODE_ON_DELAY;
         delay_ticks_ff <= '0;
         frames_ff      <= FRAMES_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMER_MODE:       timer_mode_ff  <= csr_data[MODE_WIDTH-1:0];
            CSR_DELAY_TICKS:      delay_ticks_ff <= csr_data[DELAY_WIDTH-1:0];
            CSR_FRAMES_PER_CYCLE: frames_ff      <= csr_data[FRAMES_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Timer state and result register advance together on each accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         q_level_ff     <= 1'b0;
         elapsed_ff     <= '0;
         prev_input_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_q_ff       <= 1'b0;
         rsp_elapsed_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            q_level_ff     <= q_level_in;
            elapsed_ff     <= elapsed_in;
            prev_input_ff  <= prev_input_in;
            rsp_q_ff       <= q_level_in;
            rsp_elapsed_ff <= OUT_ELAPSED_WIDTH'(elapsed_in);
         end
      end
   end

   `PLC_ASSERT_NXT(a_ton_clear, clock, reset, req_take && timer_mode_ff == MODE_ON_DELAY && !req_s_in, !q_level_ff && elapsed_ff == '0, "on-delay: low input must clear output and count")
   `PLC_ASSERT_NXT(a_tof_set, clock, reset, req_take && timer_mode_ff == MODE_OFF_DELAY && req_s_in, q_level_ff && elapsed_ff == '0, "off-delay: high input must set output and clear count")
   `PLC_ASSERT_IMP(a_rsp_state, clock, reset, rsp_valid_ff, rsp_q_ff == q_level_ff && rsp_elapsed_ff == OUT_ELAPSED_WIDTH'(elapsed_ff), "result word disagrees with timer state")
   `PLC_ASSERT_NXT(a_hold_idle, clock, reset, !req_take, $stable(elapsed_ff) && $stable(q_level_ff), "timer state moved without an accepted word")

endmodule

/* tb/tb_plc_on_off_pulse_timer.sv */
// Self-checking testbench for the on-delay / off-delay / pulse timer.
`timescale 1ns / 1ps

import plc_tmr_pkg::*;

// Tracks the timer state from accepted words and holds the readings still owed.
class timer_checker;
   typedef struct packed {
      logic        q;
      elapsed_type ticks;
   } reading_type;

   mode_type    mode;
   delay_type   delay;
   frames_type  frames;
   logic        q_level;
   elapsed_type count;
   logic        last_s;
   logic        rose;
   reading_type expected_readings[$];
   int          errors;

   function new();
      mode    = MODE_ON_DELAY;
      delay   = '0;
      frames  = FRAMES_RESET;
      q_level = 1'b0;
      count   = '0;
      last_s  = 1'b0;
      rose    = 1'b0;
      errors  = 0;
   endfunction

   function void note_write(csr_index_type index, logic [CSR_DATA_WIDTH-1:0] data);
      case (index)
         CSR_TIMER_MODE:       mode   = data[MODE_WIDTH-1:0];
         CSR_DELAY_TICKS:      delay  = data[DELAY_WIDTH-1:0];
         CSR_FRAMES_PER_CYCLE: frames = data[FRAMES_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // Step the count towards one past the delay, or creep by one once beyond it.
   function void advance_count();
      calc_type limit;
      calc_type sum;
      if (frames == 0) return;
      if (count > delay) begin
         if (count != ELAPSED_MAX) count = count + 1'b1;
         return;
      end
      limit = calc_type'(delay) + 1'b1;
      sum   = calc_type'(count) + calc_type'(frames);
      count = elapsed_type'((sum < limit) ? sum : limit);
   endfunction

   function void note_sample(logic s);
      case (mode)
         MODE_ON_DELAY: begin
            if (s && !q_level) advance_count();
            else count = '0;
            if (count > delay && s) q_level = 1'b1;
            else if (!s) q_level = 1'b0;
         end
         MODE_OFF_DELAY: begin
            if (s) begin
               q_level = 1'b1;
               count   = '0;
            end
            if (count > delay && !s) begin
               q_level = 1'b0;
               count   = '0;
            end
            if (q_level && !s) advance_count();
         end
         MODE_PULSE: begin
            rose   = s && !last_s;
            last_s = s;
            if (rose) begin
               q_level = 1'b1;
               count   = '0;
            end
            if (count > delay) begin
               q_level = 1'b0;
               count   = '0;
            end else if (q_level) begin
               advance_count();
            end
         end
         default: ;
      endcase
      expected_readings.push_back({q_level, count});
   endfunction

   task report_mismatch(string what);
      errors++;
      if (errors <= 30) $display("MISMATCH at %0t: %s", $time, what);
   endtask

   task check_reading(logic q, logic [OUT_ELAPSED_WIDTH-1:0] ticks);
      reading_type want;
      if (expected_readings.size() == 0) begin
         report_mismatch($sformatf("unexpected word q=%0b ticks=%0d", q, ticks));
         return;
      end
      want = expected_readings.pop_front();
      if (q !== want.q)
         report_mismatch($sformatf("q_out %0b, want %0b", q, want.q));
      if (ticks !== want.ticks)
         report_mismatch($sformatf("elapsed_ticks %0d, want %0d", ticks, want.ticks));
   endtask

   function int pending();
      return expected_readings.size();
   endfunction
endclass

module tb_plc_on_off_pulse_timer;

   // Mode and register index that the block leaves unused.
   localparam mode_type      MODE_UNUSED = 2'd3;
   localparam csr_index_type CSR_UNUSED  = 2'd3;
   localparam int            WORD_TARGET = 950;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_s_in;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_q_out;
   logic [OUT_ELAPSED_WIDTH-1:0] rsp_elapsed_ticks;
   logic                         csr_valid;
   logic                         csr_ready;
   csr_index_type                csr_index;
   logic [CSR_DATA_WIDTH-1:0]    csr_data;

   timer_checker tracker = new();

   bit   calm;        // no idling on either side while set
   int   hold_left;   // cycles the receiver still holds off
   int   words_sent;
   int   phase;
   logic level;

   plc_on_off_pulse_timer DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_s_in          (req_s_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_q_out         (rsp_q_out),
      .rsp_elapsed_ticks (rsp_elapsed_ticks),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // 125 MHz clock.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Drop the run if it hangs; a correct run needs a small fraction of this.
   initial begin
      #4_000_000;
      $display("tb_plc_on_off_pulse_timer failed");
      $finish;
   end

   // Receiver: idle now and then, hold off for a long stretch when asked.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= 11);
         end
      end
   end

   // Compare every word taken from the result channel.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_reading(rsp_q_out, rsp_elapsed_ticks);
   end

   // Offer one sample and hold it until the block takes it. Leave valid high
   // afterwards: the next call or an idle cycle decides what follows.
   task automatic send_sample(logic s);
      if (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_s_in  <= s;
      do @(posedge clock); while (!req_ready);
      tracker.note_sample(s);
      words_sent++;
   endtask

   // Send count samples, LSB first.
   task automatic send_pattern(logic [15:0] bits, int count);
      for (int i = 0; i < count; i++) send_sample(bits[i]);
   endtask

   // Write one register; the caller drops csr_valid after the last write.
   task automatic write_reg(csr_index_type index, logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.note_write(index, data);
   endtask

   // Stop offering, wait for every owed word, then allow the block's latency.
   task automatic settle();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (tracker.pending() != 0 && guard < 2000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2) @(posedge clock);
   endtask

   task automatic configure(mode_type m, delay_type d, logic [CSR_DATA_WIDTH-1:0] f);
      settle();
      write_reg(CSR_TIMER_MODE, CSR_DATA_WIDTH'(m));
      write_reg(CSR_DELAY_TICKS, d);
      write_reg(CSR_FRAMES_PER_CYCLE, f);
      csr_valid <= 1'b0;
   endtask

   // Rewrite a random subset of the registers; skipped ones keep the running
   // state, so mode changes mid-count come up naturally.
   task automatic shuffle_settings();
      int r;
      logic [CSR_DATA_WIDTH-1:0] value;
      settle();
      if ($urandom_range(3) != 0) begin
         value      = CSR_DATA_WIDTH'($urandom);
         value[1:0] = ($urandom_range(99) < 4) ? MODE_UNUSED
                                               : mode_type'($urandom_range(0, 2));
         write_reg(CSR_TIMER_MODE, value);
      end
      if ($urandom_range(3) != 0) begin
         r = $urandom_range(99);
         if (r < 6)       value = '0;
         else if (r < 10) value = '1;
         else if (r < 20) value = CSR_DATA_WIDTH'($urandom);
         else             value = CSR_DATA_WIDTH'($urandom_range(0, 60));
         write_reg(CSR_DELAY_TICKS, value);
      end
      if ($urandom_range(3) != 0) begin
         r     = $urandom_range(99);
         value = CSR_DATA_WIDTH'($urandom);
         if (r < 6)       value[8:0] = 9'd0;
         else if (r < 12) value[8:0] = 9'd256;
         else if (r < 18) value[8:0] = 9'd511;
         else if (r < 28) value[8:0] = FRAMES_WIDTH'($urandom);
         else             value[8:0] = FRAMES_WIDTH'($urandom_range(1, 12));
         write_reg(CSR_FRAMES_PER_CYCLE, value);
      end
      if ($urandom_range(9) == 0) write_reg(CSR_UNUSED, CSR_DATA_WIDTH'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Hold the input in runs sized to the current delay so the timer actually
   // reaches its switching points; mix in single-word glitches.
   task automatic run_random_phase(int count);
      int steps;
      int run;
      int n;
      n = 0;
      steps = (tracker.frames == 0) ? 8 : int'(tracker.delay / tracker.frames) + 2;
      if (steps > 40) steps = 40;
      while (n < count) begin
         run = ($urandom_range(99) < 15) ? 1 : $urandom_range(1, steps + 2);
         if ($urandom_range(99) < 80) level = ~level;
         else level = 1'($urandom_range(1));
         repeat (run) begin
            send_sample(level);
            n++;
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_s_in   <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_TIMER_MODE;
      csr_data   <= '0;
      calm       = 1'b0;
      hold_left  = 0;
      level      = 1'b0;
      words_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Settings straight out of reset: on-delay, zero delay, 16 per cycle.
      send_pattern(16'b011, 3);
      // On-delay, one tick per cycle: reach the delay, then release.
      configure(MODE_ON_DELAY, 24'd3, 24'd1);
      send_pattern(16'b01111, 5);
      // Off-delay, zero delay, most frames per cycle.
      configure(MODE_OFF_DELAY, 24'd0, 24'd511);
      send_pattern(16'b0001, 4);
      // Pulse: rising edges only, held input must not retrigger.
      configure(MODE_PULSE, 24'd3, 24'd2);
      send_pattern(16'b10110, 5);
      // Zero frames per cycle: the count must stand still.
      configure(MODE_OFF_DELAY, 24'd5, 24'd0);
      send_pattern(16'b001, 3);
      // Unused mode: state frozen and reported as is.
      settle();
      write_reg(CSR_TIMER_MODE, CSR_DATA_WIDTH'(MODE_UNUSED));
      csr_valid <= 1'b0;
      send_pattern(16'b01, 2);
      // Largest delay, frames field all ones with junk above it.
      configure(MODE_ON_DELAY, 24'hFFFFFF, 24'hFFFFFF);
      send_pattern(16'b111, 3);
      // Write to the unused index must be ignored.
      settle();
      write_reg(CSR_UNUSED, 24'hFFFFFF);
      csr_valid <= 1'b0;
      send_pattern(16'b1, 1);
      // Lower the delay under a running count, then switch mode mid-count.
      configure(MODE_ON_DELAY, 24'd100, 24'd7);
      send_pattern(16'b111, 3);
      settle();
      write_reg(CSR_DELAY_TICKS, 24'd2);
      csr_valid <= 1'b0;
      send_pattern(16'b1, 1);
      settle();
      write_reg(CSR_TIMER_MODE, CSR_DATA_WIDTH'(MODE_PULSE));
      csr_valid <= 1'b0;
      send_pattern(16'b01, 2);

      // Random phases: one calm stretch, one long receiver hold-off.
      words_sent = 0;
      phase      = 0;
      while (words_sent < WORD_TARGET) begin
         shuffle_settings();
         calm = (phase == 1);
         if (phase == 3) hold_left = 60;
         run_random_phase((phase == 1) ? 120 : $urandom_range(20, 60));
         phase++;
      end
      calm = 1'b0;

      settle();
      if (tracker.pending() != 0)
         tracker.report_mismatch($sformatf("%0d words never arrived", tracker.pending()));
      if (tracker.errors == 0)
         $display("tb_plc_on_off_pulse_timer passed");
      else
         $display("tb_plc_on_off_pulse_timer failed");
      $finish;
   end

endmodule
